>>> src/mtg_pkg.sv
// package: constants, types and word functions of the mt19937 generator
`timescale 1ns / 1ps

package mtg_pkg;

    localparam int WORD_W    = 32;
    localparam int N_WORDS   = 624;
    localparam int M_OFFSET  = 397;
    localparam int MAX_TRIES = 2 * N_WORDS + 1;
    localparam int IDX_W     = $clog2(N_WORDS);
    localparam int CNT_W     = $clog2(MAX_TRIES + 1);

    localparam logic [WORD_W-1:0] MATRIX_A  = 32'h9908b0df;
    localparam logic [WORD_W-1:0] UPPER     = 32'h80000000;
    localparam logic [WORD_W-1:0] LOWER     = 32'h7fffffff;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hefc60000;
    localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_DRAW
    } t_state;

    // recurrence step: upper bit of head, lower bits of next, xor with far word
    function automatic t_word mix_pair(t_word hi_word, t_word lo_word, t_word far_word);
        t_word y;
        t_word r;
        y = (hi_word & UPPER) | (lo_word & LOWER);
        r = far_word ^ (y >> 1);
        if (y[0]) begin
            r = r ^ MATRIX_A;
        end
        return r;
    endfunction

    function automatic t_word temper(t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

>>> src/mt19937_uniform_generator.sv
// top level of the mt19937 uniform word generator
`timescale 1ns / 1ps

// mt19937 uniform word generator
// a transaction is taken at a rising edge with start high and busy low
// i_mode 0 reseeds from i_seed: the 624-word state chain is filled by the
//   multiplier recurrence, one word per cycle, and busy stays high until
//   the whole chain is filled; no result is given
// i_mode 1 draws one word: the next sequence word is formed from chain taps
//   0, 1 and 397, shifted into the tail, tempered and shown on o_random_word
//   with o_valid high for one cycle, the cycle after the accept edge if the
//   word is nonzero; draws run at one per cycle while words are nonzero; a
//   tempered zero word keeps busy high while another is tried, and after
//   1249 words tried without a nonzero one the draw ends with no result
// the rate is set by the shift chain, which advances one cell per cycle
// reset clears control state only; the chain holds no defined contents
//   until a reseed, and a draw before any reseed returns arbitrary words
// the receiver cannot stall: each result is there for exactly one cycle
module mt19937_uniform_generator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           i_mode,
    input  mtg_pkg::t_word i_seed,
    output logic           o_valid,
    output mtg_pkg::t_word o_random_word
);
    import mtg_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_valid, n_valid;
    t_word              r_word, n_word;

    logic               w_accept;
    logic               w_shift;
    t_word              w_fill;
    t_word              w_twist;
    t_word              w_tempered;
    t_word              w_seed_next;
    t_word              w_cell [N_WORDS];

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // state chain: cell 0 holds the oldest word, new words enter at the tail
    for (genvar g = 0; g < N_WORDS; g++) begin : g_cell
        if (g == N_WORDS - 1) begin : g_tail
            mtg_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_data (w_fill),
                .o_data (w_cell[g])
            );
        end else begin : g_body
            mtg_cell u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_data (w_cell[g+1]),
                .o_data (w_cell[g])
            );
        end
    end

    mtg_feedback u_feedback (
        .i_head    (w_cell[0]),
        .i_next    (w_cell[1]),
        .i_far     (w_cell[M_OFFSET]),
        .i_tail    (w_cell[N_WORDS-1]),
        .i_index   (r_count[IDX_W-1:0]),
        .o_twist   (w_twist),
        .o_tempered(w_tempered),
        .o_seed    (w_seed_next)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!i_mode) begin
                        n_state = ST_SEED;
                    end else if (w_tempered == '0) begin
                        n_state = ST_DRAW;
                    end
                end
            end
            ST_SEED: begin
                if (r_count == CNT_W'(N_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAW: begin
                if ((w_tempered != '0) || (r_count == CNT_W'(MAX_TRIES - 1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // chain control, counter and result
    always_comb begin
        w_shift = 1'b0;
        w_fill  = w_twist;
        n_count = r_count;
        n_valid = 1'b0;
        n_word  = r_word;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_shift = 1'b1;
                    n_count = CNT_W'(1);
                    if (!i_mode) begin
                        // seed word goes in as word zero
                        w_fill = i_seed;
                    end else if (w_tempered != '0) begin
                        n_valid = 1'b1;
                        n_word  = w_tempered;
                    end
                end
            end
            ST_SEED: begin
                w_shift = 1'b1;
                w_fill  = w_seed_next;
                n_count = r_count + CNT_W'(1);
            end
            ST_DRAW: begin
                // a zero word was drawn, keep going until a nonzero one
                w_shift = 1'b1;
                n_count = r_count + CNT_W'(1);
                if (w_tempered != '0) begin
                    n_valid = 1'b1;
                    n_word  = w_tempered;
                end
            end
            default: begin
                w_shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_word <= n_word;
    end

    assign o_valid       = r_valid;
    assign o_random_word = r_word;

endmodule

>>> src/mtg_cell.sv
// one word cell of the state shift chain
`timescale 1ns / 1ps

module mtg_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  mtg_pkg::t_word i_data,
    output mtg_pkg::t_word o_data
);
    import mtg_pkg::*;

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_data;
        end
    end

    assign o_data = r_word;

endmodule

>>> src/mtg_feedback.sv
// feedback logic: twist word, tempered output and seeding recurrence
`timescale 1ns / 1ps

module mtg_feedback (
    input  mtg_pkg::t_word           i_head,
    input  mtg_pkg::t_word           i_next,
    input  mtg_pkg::t_word           i_far,
    input  mtg_pkg::t_word           i_tail,
    input  logic [mtg_pkg::IDX_W-1:0] i_index,
    output mtg_pkg::t_word           o_twist,
    output mtg_pkg::t_word           o_tempered,
    output mtg_pkg::t_word           o_seed
);
    import mtg_pkg::*;

    t_word w_mixed;

    assign w_mixed    = i_tail ^ (i_tail >> 30);
    assign o_twist    = mix_pair(i_head, i_next, i_far);
    assign o_tempered = temper(o_twist);
    // low half of the product only, then add the word index
    assign o_seed     = (SEED_MULT * w_mixed) + WORD_W'(i_index);

endmodule
